>>> rtl/core/bmjt_pkg.sv
// Types and fixed widths for the block max jump trigger.
// No dependencies; used by bmjt_search and block_max_jump_trigger_top.
package bmjt_pkg;

    localparam int SampleW = 16;
    localparam int IndexW  = 20;
    localparam int BlockW  = 8;
    localparam int PeakW   = 15;
    localparam int CountW  = 10;

    localparam logic [PeakW-1:0] PeakMax = {PeakW{1'b1}};

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [IndexW-1:0]         peak_index;
        logic                      first_flag;
    } in_t;

    typedef struct packed {
        logic [IndexW-1:0] jump_index;
        logic [BlockW-1:0] block_number;
        logic [PeakW-1:0]  jump_size;
        logic              error_flag;
    } out_t;

endpackage

>>> rtl/core/bmjt_search.sv
// Window search state and per-sample update: block peaks, jump compare, result.
// Depends on bmjt_pkg.
module bmjt_search #(
    parameter int BLOCK_SIZE = 32,
    parameter int WINDOW     = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  bmjt_pkg::in_t  item,
    output logic           result_push,
    output bmjt_pkg::out_t result
);

    localparam int PosW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(BLOCK_SIZE - 1);
    localparam logic [bmjt_pkg::CountW-1:0] CountLast = bmjt_pkg::CountW'(WINDOW - 1);
    localparam logic [bmjt_pkg::IndexW-1:0] WindowLen = bmjt_pkg::IndexW'(WINDOW);

    logic                            active_reg, active_next;
    logic [bmjt_pkg::CountW-1:0]     count_reg, count_next;
    logic [PosW-1:0]                 pos_reg, pos_next;
    logic [bmjt_pkg::BlockW-1:0]     block_reg, block_next;
    logic [bmjt_pkg::PeakW-1:0]      peak_reg, peak_next;
    logic [bmjt_pkg::PeakW-1:0]      prev_reg, prev_next;
    logic [bmjt_pkg::PeakW-1:0]      best_jump_reg, best_jump_next;
    logic [bmjt_pkg::IndexW-1:0]     best_index_reg, best_index_next;
    logic [bmjt_pkg::BlockW-1:0]     best_block_reg, best_block_next;
    logic [bmjt_pkg::IndexW-1:0]     wstart_reg, wstart_next;

    logic [bmjt_pkg::SampleW-1:0]    neg_sample;
    logic [bmjt_pkg::PeakW-1:0]      mag;
    logic                            too_early;
    logic [bmjt_pkg::CountW-1:0]     count_cur;
    logic [PosW-1:0]                 pos_cur;
    logic [bmjt_pkg::BlockW-1:0]     block_cur;
    logic [bmjt_pkg::PeakW-1:0]      prev_cur;
    logic [bmjt_pkg::PeakW-1:0]      best_jump_cur;
    logic [bmjt_pkg::IndexW-1:0]     best_index_cur;
    logic [bmjt_pkg::BlockW-1:0]     best_block_cur;
    logic [bmjt_pkg::IndexW-1:0]     wstart_cur;
    logic [bmjt_pkg::PeakW-1:0]      peak_new;
    logic [bmjt_pkg::PeakW-1:0]      jump;
    logic [bmjt_pkg::CountW-1:0]     block_base;
    logic                            last;
    logic                            block_end;
    logic                            better;

    always_comb
    begin
        neg_sample = bmjt_pkg::SampleW'(-item.sample);
        if (item.sample == {1'b1, {(bmjt_pkg::SampleW-1){1'b0}}})
            mag = bmjt_pkg::PeakMax;
        else if (item.sample[bmjt_pkg::SampleW-1])
            mag = neg_sample[bmjt_pkg::PeakW-1:0];
        else
            mag = item.sample[bmjt_pkg::PeakW-1:0];

        too_early = item.first_flag && (item.peak_index < WindowLen);

        count_cur      = item.first_flag ? '0 : count_reg;
        pos_cur        = item.first_flag ? '0 : pos_reg;
        block_cur      = item.first_flag ? '0 : block_reg;
        prev_cur       = item.first_flag ? '0 : prev_reg;
        best_jump_cur  = item.first_flag ? '0 : best_jump_reg;
        best_index_cur = item.first_flag ? '0 : best_index_reg;
        best_block_cur = item.first_flag ? '0 : best_block_reg;
        wstart_cur     = item.first_flag ? (item.peak_index - WindowLen) : wstart_reg;

        peak_new  = ((pos_cur == '0) || (mag > peak_reg)) ? mag : peak_reg;
        last      = (count_cur >= CountLast);
        block_end = (pos_cur == PosLast) || last;
        jump      = (peak_new > prev_cur) ? (peak_new - prev_cur) : (prev_cur - peak_new);
        better    = block_end && (jump > best_jump_cur);
        block_base = count_cur - bmjt_pkg::CountW'(pos_cur);

        active_next     = active_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        block_next      = block_reg;
        peak_next       = peak_reg;
        prev_next       = prev_reg;
        best_jump_next  = best_jump_reg;
        best_index_next = best_index_reg;
        best_block_next = best_block_reg;
        wstart_next     = wstart_reg;
        result_push     = 1'b0;
        result          = '0;

        if (step)
        begin
            if (too_early)
            begin
                active_next       = 1'b0;
                result_push       = 1'b1;
                result.error_flag = 1'b1;
            end
            else if (item.first_flag || active_reg)
            begin
                wstart_next     = wstart_cur;
                peak_next       = peak_new;
                count_next      = count_cur + 1'b1;
                pos_next        = block_end ? '0 : pos_cur + 1'b1;
                block_next      = block_end ? block_cur + 1'b1 : block_cur;
                prev_next       = block_end ? peak_new : prev_cur;
                best_jump_next  = better ? jump : best_jump_cur;
                best_index_next = better
                                  ? wstart_cur + bmjt_pkg::IndexW'(block_base)
                                  : best_index_cur;
                best_block_next = better ? block_cur : best_block_cur;
                active_next     = !last;
                if (last)
                begin
                    result_push         = 1'b1;
                    result.jump_index   = best_index_next;
                    result.block_number = best_block_next;
                    result.jump_size    = best_jump_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= '0;
            block_reg      <= '0;
            peak_reg       <= '0;
            prev_reg       <= '0;
            best_jump_reg  <= '0;
            best_index_reg <= '0;
            best_block_reg <= '0;
            wstart_reg     <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            block_reg      <= block_next;
            peak_reg       <= peak_next;
            prev_reg       <= prev_next;
            best_jump_reg  <= best_jump_next;
            best_index_reg <= best_index_next;
            best_block_reg <= best_block_next;
            wstart_reg     <= wstart_next;
        end
    end

endmodule

>>> rtl/core/block_max_jump_trigger_top.sv
// Top level of the block max jump trigger: input register, search, result queue.
// Depends on bmjt_pkg and bmjt_search.
//
// Accepts one sample transaction per cycle while sample_stall is low. Each accepted
// sample waits in the input register; the window search folds it in during the cycle in
// which it leaves. A window's result, or an early-trigger error, enters a two-entry
// result queue and shows on result_data in the cycle after the sample leaves the input
// register, unless an earlier result still waits in the queue. sample_stall rises only
// while a sample waits in the input register and both queue entries hold results that
// the receiver has not yet taken. The waiting sample is held until an entry frees.
module block_max_jump_trigger_top #(
    parameter int BLOCK_SIZE = 32,
    parameter int WINDOW     = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    output logic           sample_stall,
    input  bmjt_pkg::in_t  sample_data,
    output logic           result_valid,
    input  logic           result_stall,
    output bmjt_pkg::out_t result_data
);

    logic           in_valid_reg;
    bmjt_pkg::in_t  in_data_reg;
    logic [1:0]     fill_reg, fill_next;
    bmjt_pkg::out_t head_reg, head_next;
    bmjt_pkg::out_t skid_reg, skid_next;

    logic           queue_full;
    logic           advance;
    logic           load;
    logic           push;
    logic           pop;
    bmjt_pkg::out_t result_new;

    assign queue_full   = (fill_reg == 2'd2);
    assign advance      = in_valid_reg && !queue_full;
    assign sample_stall = in_valid_reg && queue_full;
    assign load         = !in_valid_reg || advance;
    assign result_valid = (fill_reg != 2'd0);
    assign result_data  = head_reg;
    assign pop          = result_valid && !result_stall;

    bmjt_search #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .WINDOW     (WINDOW)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_data_reg),
        .result_push (push),
        .result      (result_new)
    );

    always_comb
    begin
        fill_next = fill_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        unique case ({push, pop})
            2'b10:
            begin
                fill_next = fill_reg + 2'd1;
                if (fill_reg == 2'd0)
                    head_next = result_new;
                else
                    skid_next = result_new;
            end
            2'b01:
            begin
                fill_next = fill_reg - 2'd1;
                head_next = skid_reg;
            end
            2'b11:
            begin
                if (fill_reg == 2'd1)
                    head_next = result_new;
                else
                begin
                    head_next = skid_reg;
                    skid_next = result_new;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fill_reg     <= 2'd0;
        end
        else
        begin
            if (load)
                in_valid_reg <= sample_valid;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && sample_valid)
            in_data_reg <= sample_data;
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule
